// ===== rtl/eodt_pkg.sv =====
// Shared types and constants for the elevator order dispatch table.
// No dependencies; the RTL references this package by scoped names.
`timescale 1ns / 1ps

package eodt_pkg;

  localparam int FLOORS    = 4;
  localparam int ELEVATORS = 3;
  localparam int BUTTONS   = 3;
  localparam int ENTRIES   = FLOORS * BUTTONS;

  localparam int FL_W  = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int EL_W  = (ELEVATORS > 1) ? $clog2(ELEVATORS) : 1;
  localparam int ENT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int COST_W = 10;
  localparam int BEST_W = 14;

  localparam logic [3:0]        NO_OWNER   = 4'hF;
  localparam logic [BEST_W-1:0] NO_COST    = 14'd10000;
  localparam logic [COST_W-1:0] OTHER_COST = 10'd200;

  localparam logic [1:0] MS_MOVING = 2'd0;
  localparam logic [1:0] MS_IDLE   = 2'd1;
  localparam logic [1:0] MS_DOOR   = 2'd2;

  localparam logic [1:0] DIR_UP   = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;

  localparam logic [1:0] BTN_DOWN = 2'd1;
  localparam logic [1:0] BTN_CAB  = 2'd2;

  typedef enum logic [2:0] {
    OP_STATUS   = 3'd0,
    OP_ADD      = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_ASSIGN   = 3'd3,
    OP_NEXT     = 3'd4,
    OP_UNASSIGN = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COST,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [3:0] floor;
    logic [3:0] passed_floor;
    logic [1:0] motion;
    logic [1:0] dir;
    logic       working;
  } status_t;

endpackage

// ===== rtl/eodt_cost.sv =====
// Shared cost unit: cost of one elevator status for one order floor.
// Depends on eodt_pkg (status_t, cost constants).
`timescale 1ns / 1ps

module eodt_cost (
  input  logic [3:0]                  order_floor,
  input  eodt_pkg::status_t           status,
  output logic [eodt_pkg::COST_W-1:0] cost
);

  logic signed [5:0] diff_up;
  logic signed [5:0] diff_dn;
  logic signed [5:0] diff_fl;
  logic [4:0]        d_up;
  logic [4:0]        d_dn;
  logic [4:0]        d_fl;
  logic [eodt_pkg::COST_W-1:0] c_up;
  logic [eodt_pkg::COST_W-1:0] c_dn;
  logic [eodt_pkg::COST_W-1:0] c_fl;

  always_comb begin
    // distance to passed floor +1, passed floor -1 and the current floor
    diff_up = $signed({2'b00, order_floor}) - $signed({2'b00, status.passed_floor}) - 6'sd1;
    diff_dn = $signed({2'b00, order_floor}) - $signed({2'b00, status.passed_floor}) + 6'sd1;
    diff_fl = $signed({2'b00, order_floor}) - $signed({2'b00, status.floor});
    d_up = diff_up[5] ? 5'(-diff_up) : diff_up[4:0];
    d_dn = diff_dn[5] ? 5'(-diff_dn) : diff_dn[4:0];
    d_fl = diff_fl[5] ? 5'(-diff_fl) : diff_fl[4:0];
    c_up = {{(eodt_pkg::COST_W-5){1'b0}}, d_up};
    c_dn = {{(eodt_pkg::COST_W-5){1'b0}}, d_dn};
    c_fl = {{(eodt_pkg::COST_W-5){1'b0}}, d_fl};

    case (status.motion)
      eodt_pkg::MS_MOVING: begin
        if (order_floor > status.passed_floor) begin
          if (status.dir == eodt_pkg::DIR_UP) begin
            cost = c_up * 10'd10 + 10'd7;
          end else if (status.dir == eodt_pkg::DIR_DOWN) begin
            cost = c_dn * 10'd30;
          end else begin
            cost = '0;
          end
        end else if (order_floor < status.passed_floor) begin
          if (status.dir == eodt_pkg::DIR_UP) begin
            cost = c_up * 10'd30;
          end else if (status.dir == eodt_pkg::DIR_DOWN) begin
            cost = c_dn * 10'd10 + 10'd7;
          end else begin
            cost = '0;
          end
        end else begin
          cost = c_up * 10'd20;
        end
      end
      eodt_pkg::MS_IDLE: cost = c_fl * 10'd15 + 10'd1;
      eodt_pkg::MS_DOOR: cost = c_fl * 10'd30;
      default:           cost = eodt_pkg::OTHER_COST;
    endcase
  end

endmodule

// ===== rtl/elevator_order_dispatch_table.sv =====
// Top level: order table, status records, sequencer and output register.
// Depends on eodt_pkg and eodt_cost.
//
//  channel | dir | beat fields (tdata / tuser)
//  in_     | in  | tuser: operation; tdata: floor, button, elevator, motion_state,
//          |     |        passed_floor, direction, working
//  out_    | out | tdata: found, next_floor, next_button, chosen_elevator, best_cost
//
// Status/add/remove/unknown beats go straight to the finish state; assign of a hall
// slot walks the elevators (one elevator through the shared cost unit per cycle, other
// assigns finish at once); next scans to a hit, unassign all (one entry read per cycle).
// in_tready is high only while the sequencer is idle.
// A held result stalls the sequencer in its finish state until out_tready.
// rst_n (synchronous) clears the order table, status records and handshakes.
`timescale 1ns / 1ps

module elevator_order_dispatch_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] floor, [5:4] button, [9:6] elevator, [11:10] motion_state,
  // [15:12] passed_floor, [17:16] direction, [18] working, [23:19] zero
  input  logic [23:0] in_tdata,
  // [2:0] operation
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] found, [4:1] next_floor, [6:5] next_button, [10:7] chosen_elevator,
  // [24:11] best_cost, [31:25] zero
  output logic [31:0] out_tdata
);

  localparam int ENTRIES   = eodt_pkg::ENTRIES;
  localparam int ELEVATORS = eodt_pkg::ELEVATORS;
  localparam int FL_W      = eodt_pkg::FL_W;
  localparam int EL_W      = eodt_pkg::EL_W;
  localparam int ENT_W     = eodt_pkg::ENT_W;
  localparam int BEST_W    = eodt_pkg::BEST_W;

  eodt_pkg::state_t  state_r, state_nxt;
  eodt_pkg::op_t     op_r, op_nxt;
  logic [1:0]        bt_r, bt_nxt;
  logic [3:0]        fl_r, fl_nxt;
  logic [3:0]        ev_r, ev_nxt;
  logic [ENT_W-1:0]  idx_r, idx_nxt;

  logic              active_r [ENTRIES];
  logic              active_nxt [ENTRIES];
  logic [3:0]        owner_r [ENTRIES];
  logic [3:0]        owner_nxt [ENTRIES];
  eodt_pkg::status_t status_r [ELEVATORS];
  eodt_pkg::status_t status_nxt [ELEVATORS];

  logic [EL_W-1:0]   el_cnt_r, el_cnt_nxt;
  logic [FL_W-1:0]   sfl_r, sfl_nxt;
  logic [1:0]        sbt_r, sbt_nxt;

  logic              found_r, found_nxt;
  logic [3:0]        nfl_r, nfl_nxt;
  logic [1:0]        nbt_r, nbt_nxt;
  logic [3:0]        chosen_r, chosen_nxt;
  logic [BEST_W-1:0] best_r, best_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;

  // input beat fields
  logic [3:0]        in_floor;
  logic [1:0]        in_button;
  logic [3:0]        in_elev;
  logic              in_slot_ok;
  logic              in_elev_ok;
  logic [ENT_W-1:0]  in_idx;

  logic [ENT_W-1:0]  scan_k;
  logic              scan_hit;
  logic              scan_last;

  eodt_pkg::status_t cur_status;
  logic [eodt_pkg::COST_W-1:0] cur_cost;

  assign in_floor   = in_tdata[3:0];
  assign in_button  = in_tdata[5:4];
  assign in_elev    = in_tdata[9:6];
  assign in_slot_ok = ({1'b0, in_floor} < 5'(eodt_pkg::FLOORS)) &&
                      (in_button != 2'd3);
  assign in_elev_ok = ({1'b0, in_elev} < 5'(ELEVATORS));
  assign in_idx     = ENT_W'(in_floor[FL_W-1:0]) * ENT_W'(eodt_pkg::BUTTONS) +
                      ENT_W'(in_button);

  assign scan_k    = ENT_W'(sfl_r) * ENT_W'(eodt_pkg::BUTTONS) + ENT_W'(sbt_r);
  assign scan_hit  = active_r[scan_k] && (owner_r[scan_k] == ev_r);
  assign scan_last = (sfl_r == FL_W'(eodt_pkg::FLOORS - 1)) &&
                     (sbt_r == 2'(eodt_pkg::BUTTONS - 1));

  assign cur_status = status_r[el_cnt_r];

  eodt_cost u_cost (
    .order_floor (fl_r),
    .status      (cur_status),
    .cost        (cur_cost)
  );

  assign in_tready  = (state_r == eodt_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= eodt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        active_r[i] <= 1'b0;
        owner_r[i]  <= eodt_pkg::NO_OWNER;
      end
      for (int i = 0; i < ELEVATORS; i++) begin
        status_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      owner_r     <= owner_nxt;
      status_r    <= status_nxt;
    end
    op_r       <= op_nxt;
    bt_r       <= bt_nxt;
    fl_r       <= fl_nxt;
    ev_r       <= ev_nxt;
    idx_r      <= idx_nxt;
    el_cnt_r   <= el_cnt_nxt;
    sfl_r      <= sfl_nxt;
    sbt_r      <= sbt_nxt;
    found_r    <= found_nxt;
    nfl_r      <= nfl_nxt;
    nbt_r      <= nbt_nxt;
    chosen_r   <= chosen_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    bt_nxt        = bt_r;
    fl_nxt        = fl_r;
    ev_nxt        = ev_r;
    idx_nxt       = idx_r;
    active_nxt    = active_r;
    owner_nxt     = owner_r;
    status_nxt    = status_r;
    el_cnt_nxt    = el_cnt_r;
    sfl_nxt       = sfl_r;
    sbt_nxt       = sbt_r;
    found_nxt     = found_r;
    nfl_nxt       = nfl_r;
    nbt_nxt       = nbt_r;
    chosen_nxt    = chosen_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      eodt_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = eodt_pkg::op_t'(in_tuser);
          bt_nxt     = in_button;
          fl_nxt     = in_floor;
          ev_nxt     = in_elev;
          idx_nxt    = in_idx;
          el_cnt_nxt = '0;
          sfl_nxt    = '0;
          sbt_nxt    = '0;
          found_nxt  = 1'b0;
          nfl_nxt    = '0;
          nbt_nxt    = eodt_pkg::BTN_DOWN;
          chosen_nxt = eodt_pkg::NO_OWNER;
          best_nxt   = eodt_pkg::NO_COST;
          state_nxt  = eodt_pkg::ST_DONE;
          case (eodt_pkg::op_t'(in_tuser))
            eodt_pkg::OP_STATUS: begin
              if (in_elev_ok) begin
                status_nxt[in_elev[EL_W-1:0]] = '{
                  floor:        in_floor,
                  passed_floor: in_tdata[15:12],
                  motion:       in_tdata[11:10],
                  dir:          in_tdata[17:16],
                  working:      in_tdata[18]
                };
              end
            end
            eodt_pkg::OP_ADD: begin
              if (in_slot_ok) begin
                active_nxt[in_idx] = 1'b1;
                owner_nxt[in_idx]  = in_elev;
              end
            end
            eodt_pkg::OP_REMOVE: begin
              if (in_slot_ok) begin
                active_nxt[in_idx] = 1'b0;
                owner_nxt[in_idx]  = eodt_pkg::NO_OWNER;
              end
            end
            eodt_pkg::OP_ASSIGN: begin
              if (in_slot_ok && in_button != eodt_pkg::BTN_CAB) begin
                state_nxt = eodt_pkg::ST_COST;
              end
            end
            eodt_pkg::OP_NEXT:     state_nxt = eodt_pkg::ST_SCAN;
            eodt_pkg::OP_UNASSIGN: state_nxt = eodt_pkg::ST_SCAN;
            default: ;
          endcase
        end
      end

      eodt_pkg::ST_COST: begin
        // strict compare keeps the lowest index on ties
        if (cur_status.working && (BEST_W'(cur_cost) < best_r)) begin
          best_nxt   = BEST_W'(cur_cost);
          chosen_nxt = 4'(el_cnt_r);
        end
        if (el_cnt_r == EL_W'(ELEVATORS - 1)) begin
          active_nxt[idx_r] = 1'b1;
          owner_nxt[idx_r]  = chosen_nxt;
          state_nxt         = eodt_pkg::ST_DONE;
        end else begin
          el_cnt_nxt = el_cnt_r + 1'b1;
        end
      end

      eodt_pkg::ST_SCAN: begin
        if (op_r == eodt_pkg::OP_NEXT && scan_hit) begin
          found_nxt = 1'b1;
          nfl_nxt   = 4'(sfl_r);
          nbt_nxt   = sbt_r;
          state_nxt = eodt_pkg::ST_DONE;
        end else begin
          // unassign only touches hall buttons
          if (op_r == eodt_pkg::OP_UNASSIGN && scan_hit &&
              sbt_r != eodt_pkg::BTN_CAB) begin
            owner_nxt[scan_k] = eodt_pkg::NO_OWNER;
          end
          if (scan_last) begin
            state_nxt = eodt_pkg::ST_DONE;
          end else if (sbt_r == 2'(eodt_pkg::BUTTONS - 1)) begin
            sbt_nxt = '0;
            sfl_nxt = sfl_r + 1'b1;
          end else begin
            sbt_nxt = sbt_r + 2'd1;
          end
        end
      end

      eodt_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, best_r, chosen_r, nbt_r, nfl_r, found_r};
          state_nxt     = eodt_pkg::ST_IDLE;
        end
      end

      default: state_nxt = eodt_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== bench/dispatch_checker.sv =====
// Checker for the elevator order dispatch table: watches both stream channels,
// keeps its own copy of the order table and status records, predicts each reply.
// Depends on eodt_pkg for sizes, codes and the status record layout.
`timescale 1ns / 1ps

module dispatch_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // [3:0] floor, [5:4] button, [9:6] elevator, [11:10] motion_state,
  // [15:12] passed_floor, [17:16] direction, [18] working, [23:19] zero
  input  logic [23:0] in_tdata,
  // [2:0] operation
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // [0] found, [4:1] next_floor, [6:5] next_button, [10:7] chosen_elevator,
  // [24:11] best_cost, [31:25] zero
  input  logic [31:0] out_tdata,
  output int          mismatches,
  output int          pending,
  output int          checked,
  output int          hits,
  output int          wins
);
  import eodt_pkg::*;

  typedef struct packed {
    logic        found;
    logic [3:0]  floor;
    logic [1:0]  button;
    logic [3:0]  chosen;
    logic [13:0] cost;
  } reply_t;

  logic       active_q [ENTRIES];
  logic [3:0] owner_q  [ENTRIES];
  status_t    lifts    [ELEVATORS];
  reply_t     replies_due [$];
  int         errs;
  int         n_checked;
  int         n_hits;
  int         n_wins;

  function automatic int span(input int a, input int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int lift_cost(input int f, input status_t s);
    int lf;
    int at;
    lf = int'(s.passed_floor);
    at = int'(s.floor);
    case (s.motion)
      MS_MOVING: begin
        if (f == lf) return span(f, lf + 1) * 20;
        if (s.dir == DIR_UP)
          return (f > lf) ? span(f, lf + 1) * 10 + 7 : span(f, lf + 1) * 30;
        if (s.dir == DIR_DOWN)
          return (f > lf) ? span(f, lf - 1) * 30 : span(f, lf - 1) * 10 + 7;
        return 0;  // stopped while moving
      end
      MS_IDLE: return span(f, at) * 15 + 1;
      MS_DOOR: return span(f, at) * 30;
      default: return int'(OTHER_COST);
    endcase
  endfunction

  // Applies one beat to the shadow tables and returns the reply it should produce.
  function automatic reply_t table_step(input logic [2:0] op, input logic [23:0] d);
    reply_t     r;
    logic [3:0] fl;
    logic [3:0] ev;
    logic [3:0] lf;
    logic [1:0] bt;
    logic [1:0] ms;
    logic [1:0] dr;
    logic       wk;
    int         evs;
    int         idx;
    int         c;
    int         best;
    bit         slot_ok;
    bit         done;
    fl = d[3:0];
    bt = d[5:4];
    ev = d[9:6];
    ms = d[11:10];
    lf = d[15:12];
    dr = d[17:16];
    wk = d[18];
    evs = ev[3] ? int'(ev) - 16 : int'(ev);
    slot_ok = (int'(fl) < FLOORS) && (int'(bt) < BUTTONS);
    idx = slot_ok ? int'(fl) * BUTTONS + int'(bt) : 0;
    r.found  = 1'b0;
    r.floor  = 4'd0;
    r.button = BTN_DOWN;
    r.chosen = NO_OWNER;
    r.cost   = NO_COST;
    case (op)
      OP_STATUS: begin
        if (evs >= 0 && evs < ELEVATORS) begin
          lifts[evs].floor        = fl;
          lifts[evs].passed_floor = lf;
          lifts[evs].motion       = ms;
          lifts[evs].dir          = dr;
          lifts[evs].working      = wk;
        end
      end
      OP_ADD: begin
        if (slot_ok) begin
          active_q[idx] = 1'b1;
          owner_q[idx]  = ev;
        end
      end
      OP_REMOVE: begin
        if (slot_ok) begin
          active_q[idx] = 1'b0;
          owner_q[idx]  = NO_OWNER;
        end
      end
      OP_ASSIGN: begin
        if (slot_ok && bt != BTN_CAB) begin
          best = int'(NO_COST);
          for (int e = 0; e < ELEVATORS; e++) begin
            if (lifts[e].working) begin
              c = lift_cost(int'(fl), lifts[e]);
              if (c < best) begin
                best = c;
                r.chosen = 4'(e);
              end
            end
          end
          r.cost = 14'(best);
          active_q[idx] = 1'b1;
          owner_q[idx]  = r.chosen;
        end
      end
      OP_NEXT: begin
        done = 1'b0;
        for (int f = 0; f < FLOORS; f++) begin
          for (int b = 0; b < BUTTONS; b++) begin
            if (!done && active_q[f * BUTTONS + b] && owner_q[f * BUTTONS + b] == ev) begin
              done     = 1'b1;
              r.found  = 1'b1;
              r.floor  = 4'(f);
              r.button = 2'(b);
            end
          end
        end
      end
      OP_UNASSIGN: begin
        // hall buttons only; cab orders keep their owner
        for (int f = 0; f < FLOORS; f++) begin
          for (int b = 0; b < 2; b++) begin
            if (active_q[f * BUTTONS + b] && owner_q[f * BUTTONS + b] == ev)
              owner_q[f * BUTTONS + b] = NO_OWNER;
          end
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errs++;
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (!rst_n) begin
      for (int k = 0; k < ENTRIES; k++) begin
        active_q[k] = 1'b0;
        owner_q[k]  = NO_OWNER;
      end
      for (int e = 0; e < ELEVATORS; e++)
        lifts[e] = '0;
      replies_due.delete();
    end else begin
      if (in_tvalid && in_tready)
        replies_due.insert(replies_due.size(), table_step(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", int'(out_tdata), 0);
        end else begin
          want = replies_due.pop_front();
          n_checked++;
          if (out_tdata[0] != want.found)
            report_mismatch("found", int'(out_tdata[0]), int'(want.found));
          if (out_tdata[4:1] != want.floor)
            report_mismatch("next_floor", int'(out_tdata[4:1]), int'(want.floor));
          if (out_tdata[6:5] != want.button)
            report_mismatch("next_button", int'(out_tdata[6:5]), int'(want.button));
          if (out_tdata[10:7] != want.chosen)
            report_mismatch("chosen_elevator", int'(out_tdata[10:7]), int'(want.chosen));
          if (out_tdata[24:11] != want.cost)
            report_mismatch("best_cost", int'(out_tdata[24:11]), int'(want.cost));
          if (out_tdata[31:25] != 7'd0)
            report_mismatch("tdata padding", int'(out_tdata[31:25]), 0);
          if (want.found) n_hits++;
          if (want.chosen != NO_OWNER) n_wins++;
        end
      end
    end
    pending    <= replies_due.size();
    mismatches <= errs;
    checked    <= n_checked;
    hits       <= n_hits;
    wins       <= n_wins;
  end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus and verdict for the elevator order dispatch table.
// Depends on eodt_pkg, the block itself and dispatch_checker.
`timescale 1ns / 1ps

module tb_top;
  import eodt_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 4 * ENTRIES;

  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;
  localparam logic [1:0] BTN_UP    = 2'd0;
  localparam logic [1:0] BTN_BAD   = 2'd3;
  localparam logic [1:0] MS_OTHER  = 2'd3;
  localparam logic [1:0] DIR_STOP  = 2'd2;
  localparam logic [1:0] DIR_ODD   = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  int mismatches;
  int pending;
  int checked;
  int hits;
  int wins;
  int beats = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  bit calm = 1'b0;
  bit hold_long = 1'b0;

  elevator_order_dispatch_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  dispatch_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .hits       (hits),
    .wins       (wins)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [23:0] pack_fields(input logic [3:0] fl, input logic [1:0] bt,
                                              input logic [3:0] ev, input logic [1:0] ms,
                                              input logic [3:0] lf, input logic [1:0] dr,
                                              input logic wk);
    return {5'd0, wk, dr, lf, ms, ev, bt, fl};
  endfunction

  // Offers one beat, waits for it to be taken, then maybe drops valid for a while.
  task automatic send(input logic [2:0] op, input logic [23:0] d);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats++;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic send_fields(input logic [2:0] op, input logic [3:0] fl, input logic [1:0] bt,
                             input logic [3:0] ev, input logic [1:0] ms, input logic [3:0] lf,
                             input logic [1:0] dr, input logic wk);
    send(op, pack_fields(fl, bt, ev, ms, lf, dr, wk));
  endtask

  // Stop offering and let every outstanding reply come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          r;
    logic [2:0]  op;
    logic [3:0]  fl;
    logic [3:0]  ev;
    logic [3:0]  lf;
    logic [1:0]  bt;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table, then assign with nobody working
    send_fields(OP_NEXT,   4'd0, BTN_UP, 4'd0,     MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_ASSIGN, 4'd0, BTN_UP, 4'd0,     MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_NEXT,   4'd0, BTN_UP, NO_OWNER, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    // three working elevators, plus updates for out-of-range indexes
    send_fields(OP_STATUS, 4'd1, BTN_UP, 4'd0, MS_MOVING, 4'd1, DIR_UP, 1'b1);
    send_fields(OP_STATUS, 4'd3, BTN_UP, 4'd1, MS_IDLE,   4'd3, DIR_STOP, 1'b1);
    send_fields(OP_STATUS, 4'd0, BTN_UP, 4'd2, MS_DOOR,   4'd0, DIR_DOWN, 1'b1);
    send_fields(OP_STATUS, 4'd15, BTN_BAD, NO_OWNER, MS_OTHER, 4'd15, DIR_ODD, 1'b1);
    send_fields(OP_STATUS, 4'd2, BTN_UP, 4'd7, MS_IDLE, 4'd2, DIR_UP, 1'b1);
    // assigns: normal, cab, bad floor, bad button
    send_fields(OP_ASSIGN, 4'd3,  BTN_DOWN, 4'd0, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_ASSIGN, 4'd2,  BTN_CAB,  4'd0, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_ASSIGN, 4'd15, BTN_UP,   4'd0, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_ASSIGN, 4'd1,  BTN_BAD,  4'd0, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    // adds, including out-of-range slots and a negative owner
    send_fields(OP_ADD, 4'd3,  BTN_CAB,  4'd2, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_ADD, 4'd15, BTN_UP,   4'd2, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_ADD, 4'd0,  BTN_BAD,  4'd2, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_ADD, 4'd2,  BTN_DOWN, 4'd8, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_NEXT, 4'd0, BTN_UP, 4'd1, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    // unassign an owner, then the unassigned pattern itself
    send_fields(OP_UNASSIGN, 4'd0, BTN_UP, 4'd1,     MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_UNASSIGN, 4'd0, BTN_UP, NO_OWNER, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_NEXT,     4'd0, BTN_UP, NO_OWNER, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_REMOVE, 4'd3,  BTN_DOWN, 4'd0, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_REMOVE, 4'd15, BTN_DOWN, 4'd0, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_BAD_LO, 4'd1, BTN_UP, 4'd0, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_BAD_HI, 4'd1, BTN_UP, 4'd0, MS_MOVING, 4'd0, DIR_UP, 1'b0);
    send_fields(OP_STATUS, 4'd15, BTN_UP, 4'd0, MS_OTHER, 4'd15, DIR_ODD, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ITEMS - 150) quiet = 1'b1;
      if (i == 300) hold_long = 1'b1;
      if (i == 700 || i == 1000) drain();
      r = $urandom_range(0, 99);
      if (r < 18)      op = OP_STATUS;
      else if (r < 33) op = OP_ADD;
      else if (r < 43) op = OP_REMOVE;
      else if (r < 63) op = OP_ASSIGN;
      else if (r < 83) op = OP_NEXT;
      else if (r < 96) op = OP_UNASSIGN;
      else             op = ($urandom_range(0, 1) == 0) ? OP_BAD_LO : OP_BAD_HI;
      fl = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(0, FLOORS - 1));
      bt = ($urandom_range(0, 15) == 0) ? BTN_BAD : 2'($urandom_range(0, BUTTONS - 1));
      lf = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15))
                                       : 4'($urandom_range(0, FLOORS - 1));
      r = $urandom_range(0, 99);
      if (r < 70)      ev = 4'($urandom_range(0, ELEVATORS - 1));
      else if (r < 85) ev = NO_OWNER;
      else             ev = 4'($urandom_range(0, 15));
      send(op, pack_fields(fl, bt, ev, 2'($urandom_range(0, 3)), lf,
                           2'($urandom_range(0, 3)), $urandom_range(0, 4) != 0));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d beats sent, %0d replies checked, %0d next-order hits, %0d won assigns",
             beats, checked, hits, wins);
    $display("summary: status, add, remove, assign, next, unassign and unknown ops, with stalls");
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
